[sv/tcm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcm_pkg;

  localparam int DATA_W     = 8;
  localparam int OFFS_W     = 31;
  localparam int WORD_W     = 32;
  localparam int IV_W       = 48;
  localparam int BLK_W      = 64;
  localparam int CTR_LO_W   = 16;
  localparam int POS_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int ROUNDS_DEF = 32;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;
  localparam logic [IV_W-1:0]   IV_RST    = 48'hFF00_0000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IV   = 3'd4;

  typedef struct packed {
    logic accept;
    logic start;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_blk;
  } sts_t;

  // one half-round mixing term
  function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] x,
                                                input logic [WORD_W-1:0] s,
                                                input logic [WORD_W-1:0] ka,
                                                input logic [WORD_W-1:0] kb);
    return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

endpackage

`default_nettype wire

[sv/tcm_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tcm_in_if;
  import tcm_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              first;
  logic [OFFS_W-1:0] stream_offset;
  logic              last_in;
  modport source(output valid, data_byte, first, stream_offset, last_in, input ready);
  modport sink(input valid, data_byte, first, stream_offset, last_in, output ready);
endinterface

interface tcm_out_if;
  import tcm_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_byte;
  logic              out_last;
  modport source(output valid, out_byte, out_last, input ready);
  modport sink(input valid, out_byte, out_last, output ready);
endinterface

interface tcm_cfg_if;
  import tcm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;
  modport source(output valid, idx, wdata, input ready);
  modport sink(input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

[sv/tcm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcm_ctrl #(
  parameter int ROUNDS = tcm_pkg::ROUNDS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire tcm_pkg::sts_t sts,
  output tcm_pkg::cmd_t      cmd
);
  import tcm_pkg::*;

  localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             rnd_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign rnd_last  = (rnd_r == RND_LAST);

  assign cmd.accept = (state_r == ST_IDLE) && in_valid;
  assign cmd.start  = cmd.accept && sts.need_blk;
  assign cmd.step   = (state_r == ST_RUN);
  assign cmd.emit   = (state_r == ST_HOLD) && out_free;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = sts.need_blk ? ST_RUN : ST_HOLD;
          rnd_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (rnd_last) begin
          state_nxt = ST_HOLD;
          rnd_nxt   = '0;
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      ST_HOLD: begin
        if (cmd.emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        rnd_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/tcm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcm_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tcm_pkg::cmd_t                  cmd,
  output tcm_pkg::sts_t                       sts,
  input  wire logic [tcm_pkg::DATA_W-1:0]     in_data,
  input  wire logic                           in_first,
  input  wire logic [tcm_pkg::OFFS_W-1:0]     in_offset,
  input  wire logic                           in_last,
  input  wire logic                           cfg_we,
  input  wire logic [tcm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [tcm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [tcm_pkg::DATA_W-1:0]          out_byte,
  output logic                                out_last
);
  import tcm_pkg::*;

  logic [WORD_W-1:0] key0_r, key1_r, key2_r, key3_r;
  logic [IV_W-1:0]   iv_r;
  logic [BLK_W-1:0]  ctr_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] a_r, b_r, s_r;
  logic [DATA_W-1:0] data_r;
  logic              last_r;
  logic [DATA_W-1:0] out_byte_r;
  logic              out_last_r;

  logic [BLK_W-1:0]  eff_ctr;
  logic [POS_W-1:0]  eff_pos;
  logic [WORD_W-1:0] s_nxt, a_nxt, b_nxt;
  logic [BLK_W-1:0]  ks;
  logic [DATA_W-1:0] ks_byte;

  // a fresh block is due on every message start and at each wrap of the position
  assign sts.need_blk = in_first || (pos_r == '0);

  assign eff_ctr = in_first ? {iv_r, in_offset[POS_W +: CTR_LO_W]} : ctr_r;
  assign eff_pos = in_first ? in_offset[POS_W-1:0] : pos_r;

  assign s_nxt = s_r + TEA_DELTA;
  assign a_nxt = a_r + tea_mix(b_r, s_nxt, key0_r, key1_r);
  assign b_nxt = b_r + tea_mix(a_nxt, s_nxt, key2_r, key3_r);

  // big-endian: position 0 is the top byte
  assign ks      = {a_r, b_r};
  assign ks_byte = ks[BLK_W - DATA_W - DATA_W * pos_r +: DATA_W];

  assign out_byte = out_byte_r;
  assign out_last = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
      iv_r   <= IV_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_KEY0: key0_r <= cfg_wdata[WORD_W-1:0];
        CFG_KEY1: key1_r <= cfg_wdata[WORD_W-1:0];
        CFG_KEY2: key2_r <= cfg_wdata[WORD_W-1:0];
        CFG_KEY3: key3_r <= cfg_wdata[WORD_W-1:0];
        CFG_IV:   iv_r   <= cfg_wdata[IV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
      pos_r <= '0;
      a_r   <= '0;
      b_r   <= '0;
      s_r   <= '0;
    end else begin
      if (cmd.accept) begin
        pos_r <= eff_pos;
      end else if (cmd.emit) begin
        pos_r <= pos_r + 1'b1;
      end
      if (cmd.start) begin
        ctr_r <= eff_ctr + 1'b1;
        a_r   <= eff_ctr[BLK_W-1:WORD_W];
        b_r   <= eff_ctr[WORD_W-1:0];
        s_r   <= '0;
      end else if (cmd.step) begin
        a_r <= a_nxt;
        b_r <= b_nxt;
        s_r <= s_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_r <= in_data;
      last_r <= in_last;
    end
    if (cmd.emit) begin
      out_byte_r <= data_r ^ ks_byte;
      out_last_r <= last_r;
    end
  end

endmodule

`default_nettype wire

[sv/tea_counter_mode_stream_cipher_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  beat payload                                    accepted when
// in_bus   in   data_byte, first, stream_offset, last_in         valid && ready
// out_bus  out  out_byte, out_last                               valid && ready
// cfg_bus  in   idx (register index), wdata                      valid && ready (always ready)
//
// a byte that opens a keystream block (message start or position wrap) first runs the
// TEA rounds, one TEA round per cycle in the shared round unit, before it is emitted.
// other bytes skip the round unit and go straight from acceptance to emit.
// reset is synchronous, active low; no memories, no clearing pass.
// a result waiting on out_bus does not block the next input beat from starting.

module tea_counter_mode_stream_cipher_unit #(
  parameter int ROUNDS = tcm_pkg::ROUNDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tcm_in_if.sink     in_bus,
  tcm_out_if.source  out_bus,
  tcm_cfg_if.sink    cfg_bus
);
  import tcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_bus.ready = 1'b1;

  tcm_ctrl #(
    .ROUNDS(ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .out_valid(out_bus.valid),
    .out_ready(out_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcm_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_bus.data_byte),
    .in_first (in_bus.first),
    .in_offset(in_bus.stream_offset),
    .in_last  (in_bus.last_in),
    .cfg_we   (cfg_bus.valid),
    .cfg_idx  (cfg_bus.idx),
    .cfg_wdata(cfg_bus.wdata),
    .out_byte (out_bus.out_byte),
    .out_last (out_bus.out_last)
  );

endmodule

`default_nettype wire
